@@ rtl/core/hbmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-move table package
// Shared constants, types and a helper function of the hashed best-move table.
// ----------------------------------------------------------------------------
`default_nettype none

package hbmt_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int MOVE_BITS     = 25;
    localparam int KEY_BITS      = 64;
    localparam int CFG_BITS      = 13;
    localparam int ENTRIES_RESET = 4096;

    localparam int SLOT_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DIV_BITS  = SLOT_BITS + 1;
    localparam int CNT_BITS  = $clog2(KEY_BITS);

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_STORE = 2'd1,
        MODE_PROBE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [MOVE_BITS-1:0] move;
    } t_entry;

    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [SLOT_BITS-1:0] remainder;
    } t_div_sts;

    function automatic logic [DIV_BITS-1:0] effective_divisor(input logic [CFG_BITS-1:0] cfg);
        logic [DIV_BITS-1:0] d;
        if (cfg == '0) begin
            d = DIV_BITS'(1);
        end else if (int'(cfg) > TABLE_DEPTH) begin
            d = DIV_BITS'(TABLE_DEPTH);
        end else begin
            d = DIV_BITS'(cfg);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hbmt_if.sv @@
// ----------------------------------------------------------------------------
// Best-move table channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbmt_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [hbmt_pkg::KEY_BITS-1:0] hash_key;
    logic [hbmt_pkg::MOVE_BITS-1:0] move_code;

    modport source (output valid, mode, hash_key, move_code, input ready);
    modport sink (input valid, mode, hash_key, move_code, output ready);
endinterface

interface hbmt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [hbmt_pkg::MOVE_BITS-1:0] found_move;

    modport source (output valid, hit, found_move, input ready);
    modport sink (input valid, hit, found_move, output ready);
endinterface

interface hbmt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hbmt_pkg::CFG_BITS-1:0] entries_in_use;

    modport source (output valid, entries_in_use, input ready);
    modport sink (input valid, entries_in_use, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hashed_best_move_table_unit.sv @@
// ----------------------------------------------------------------------------
// Hashed best-move table
// Direct-mapped table of best moves indexed by position key modulo the
// configured number of slots in use.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_in (mode, hash_key, move_code); each
// accepted transaction yields exactly one result transaction on o_out
// (hit, found_move). A store writes key and move into its slot, a probe
// returns the stored move only when the stored key matches, and a clear
// zeroes every slot. The slot count is written through i_cfg at any time
// the unit is idle; it is always accepted.
// Sequencing: the slot index comes from a one-bit-per-cycle modulo unit;
// a store then writes its slot and replies, while a probe first compares
// the stored key. A clear sweeps the table RAM one entry per cycle, and an
// unused mode returns a zero result. One transaction is processed at a
// time; i_in.ready is high only while the sequencer idles. After reset
// the unit clears the table with i_in.ready low, producing no result. The
// result sits in an output register, so a new request is taken while
// o_out stalls; that request then completes once the receiver has taken
// the earlier result.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_best_move_table_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hbmt_in_if.sink     i_in,
    hbmt_out_if.source  o_out,
    hbmt_cfg_if.sink    i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WIPE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [1:0]                      r_mode;
    logic [1:0]                      n_mode;
    logic [hbmt_pkg::KEY_BITS-1:0]   r_key;
    logic [hbmt_pkg::KEY_BITS-1:0]   n_key;
    logic [hbmt_pkg::MOVE_BITS-1:0]  r_move_in;
    logic [hbmt_pkg::MOVE_BITS-1:0]  n_move_in;
    logic [hbmt_pkg::SLOT_BITS-1:0]  r_wipe_idx;
    logic [hbmt_pkg::SLOT_BITS-1:0]  n_wipe_idx;
    logic                            r_wipe_reply;
    logic                            n_wipe_reply;
    logic                            r_res_hit;
    logic                            n_res_hit;
    logic [hbmt_pkg::MOVE_BITS-1:0]  r_res_move;
    logic [hbmt_pkg::MOVE_BITS-1:0]  n_res_move;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            r_out_hit;
    logic                            n_out_hit;
    logic [hbmt_pkg::MOVE_BITS-1:0]  r_out_move;
    logic [hbmt_pkg::MOVE_BITS-1:0]  n_out_move;
    logic [hbmt_pkg::CFG_BITS-1:0]   r_entries;
    logic [hbmt_pkg::CFG_BITS-1:0]   n_entries;

    logic                            in_fire;
    logic                            ram_we;
    logic [hbmt_pkg::SLOT_BITS-1:0]  ram_waddr;
    hbmt_pkg::t_entry                ram_wdata;
    hbmt_pkg::t_entry                ram_rdata;
    hbmt_pkg::t_div_req              div_req;
    hbmt_pkg::t_div_sts              div_sts;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign div_req.start    = in_fire && ((hbmt_pkg::t_mode'(i_in.mode) == hbmt_pkg::MODE_STORE)
                              || (hbmt_pkg::t_mode'(i_in.mode) == hbmt_pkg::MODE_PROBE));
    assign div_req.dividend = i_in.hash_key;
    assign div_req.divisor  = hbmt_pkg::effective_divisor(r_entries);

    hbmt_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    hbmt_ram #(
        .WIDTH ($bits(hbmt_pkg::t_entry)),
        .DEPTH (hbmt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (div_sts.remainder),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_move_in    = r_move_in;
        n_wipe_idx   = r_wipe_idx;
        n_wipe_reply = r_wipe_reply;
        n_res_hit    = r_res_hit;
        n_res_move   = r_res_move;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_hit    = r_out_hit;
        n_out_move   = r_out_move;
        n_entries    = r_entries;
        ram_we       = 1'b0;
        ram_waddr    = r_wipe_idx;
        ram_wdata    = '0;

        if (i_cfg.valid) begin
            n_entries = i_cfg.entries_in_use;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_mode    = i_in.mode;
                    n_key     = i_in.hash_key;
                    n_move_in = i_in.move_code;
                    case (hbmt_pkg::t_mode'(i_in.mode))
                        hbmt_pkg::MODE_CLEAR: begin
                            n_wipe_idx   = '0;
                            n_wipe_reply = 1'b1;
                            n_state      = S_WIPE;
                        end
                        hbmt_pkg::MODE_STORE,
                        hbmt_pkg::MODE_PROBE: begin
                            n_state = S_DIV;
                        end
                        default: begin
                            n_res_hit  = 1'b0;
                            n_res_move = '0;
                            n_state    = S_EMIT;
                        end
                    endcase
                end
            end
            S_WIPE: begin
                ram_we     = 1'b1;
                n_wipe_idx = r_wipe_idx + hbmt_pkg::SLOT_BITS'(1);
                if (r_wipe_idx == hbmt_pkg::SLOT_BITS'(hbmt_pkg::TABLE_DEPTH - 1)) begin
                    n_res_hit  = 1'b0;
                    n_res_move = '0;
                    n_state    = r_wipe_reply ? S_EMIT : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (hbmt_pkg::t_mode'(r_mode) == hbmt_pkg::MODE_STORE) begin
                        ram_we         = 1'b1;
                        ram_waddr      = div_sts.remainder;
                        ram_wdata.key  = r_key;
                        ram_wdata.move = r_move_in;
                        n_res_hit      = 1'b0;
                        n_res_move     = '0;
                        n_state        = S_EMIT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_res_hit  = (ram_rdata.key == r_key);
                n_res_move = (ram_rdata.key == r_key) ? ram_rdata.move : '0;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_move  = r_res_move;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WIPE;
            r_wipe_idx   <= '0;
            r_wipe_reply <= 1'b0;
            r_out_valid  <= 1'b0;
            r_entries    <= hbmt_pkg::CFG_BITS'(hbmt_pkg::ENTRIES_RESET);
        end else begin
            r_state      <= n_state;
            r_wipe_idx   <= n_wipe_idx;
            r_wipe_reply <= n_wipe_reply;
            r_out_valid  <= n_out_valid;
            r_entries    <= n_entries;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_move_in  <= n_move_in;
        r_res_hit  <= n_res_hit;
        r_res_move <= n_res_move;
        r_out_hit  <= n_out_hit;
        r_out_move <= n_out_move;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out_hit;
    assign o_out.found_move = r_out_move;

`ifndef ASSERT_OFF
    a_lookup_starts_modulo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == S_DIV))
        else $error("Store or probe did not start the modulo unit.");

    a_check_follows_modulo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_DIV) && $past(div_sts.done))
        else $error("Key check entered without a finished slot index.");

    a_miss_has_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_move == '0))
        else $error("Result without a hit carries a move.");
`endif

endmodule

`default_nettype wire

@@ rtl/core/hbmt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/hbmt_mod.sv @@
// ----------------------------------------------------------------------------
// Iterative key modulo unit
// Restoring remainder unit that reduces the key by the slot count, one key
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmt_mod (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hbmt_pkg::t_div_req i_req,
    output hbmt_pkg::t_div_sts      o_sts
);

    logic                                r_busy;
    logic                                n_busy;
    logic                                r_done;
    logic                                n_done;
    logic [hbmt_pkg::CNT_BITS-1:0]       r_cnt;
    logic [hbmt_pkg::CNT_BITS-1:0]       n_cnt;
    logic [hbmt_pkg::KEY_BITS-1:0]       r_quot;
    logic [hbmt_pkg::KEY_BITS-1:0]       n_quot;
    logic [hbmt_pkg::SLOT_BITS-1:0]      r_rem;
    logic [hbmt_pkg::SLOT_BITS-1:0]      n_rem;
    logic [hbmt_pkg::DIV_BITS-1:0]       r_divisor;
    logic [hbmt_pkg::DIV_BITS-1:0]       n_divisor;
    logic [hbmt_pkg::DIV_BITS-1:0]       shifted;

    assign shifted = {r_rem, r_quot[hbmt_pkg::KEY_BITS-1]};

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_cnt     = hbmt_pkg::CNT_BITS'(hbmt_pkg::KEY_BITS - 1);
            n_quot    = i_req.dividend;
            n_rem     = '0;
            n_divisor = i_req.divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[hbmt_pkg::KEY_BITS-2:0], 1'b0};
            if (shifted >= r_divisor) begin
                n_rem = hbmt_pkg::SLOT_BITS'(shifted - r_divisor);
            end else begin
                n_rem = hbmt_pkg::SLOT_BITS'(shifted);
            end
            n_cnt = r_cnt - hbmt_pkg::CNT_BITS'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt     <= n_cnt;
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_sts.done      = r_done;
    assign o_sts.remainder = r_rem;

`ifndef ASSERT_OFF
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < r_divisor))
        else $error("Remainder is not below the divisor.");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hashed best-move table testbench
// Drives store, probe, clear and unused-mode requests through several table
// sizes, with random idle bursts on both channels. A scoreboard keeps its own
// copy of the table and checks every result transaction in order.
// ----------------------------------------------------------------------------

module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         POOL_LIMIT  = 24;

    typedef struct packed {
        logic                           hit;
        logic [hbmt_pkg::MOVE_BITS-1:0] found_move;
    } t_lookup_result;

    class t_best_move_scoreboard;
        logic [hbmt_pkg::KEY_BITS-1:0]  slot_key [hbmt_pkg::TABLE_DEPTH];
        logic [hbmt_pkg::MOVE_BITS-1:0] slot_move [hbmt_pkg::TABLE_DEPTH];
        logic [hbmt_pkg::CFG_BITS-1:0]  entries;
        t_lookup_result                 expected_lookups[$];
        int errors;
        int stores;
        int probes;
        int hits;
        int clears;
        int unused;
        int checked;

        function new();
            wipe_table();
            entries = hbmt_pkg::CFG_BITS'(hbmt_pkg::ENTRIES_RESET);
        endfunction

        function void wipe_table();
            foreach (slot_key[i]) begin
                slot_key[i]  = '0;
                slot_move[i] = '0;
            end
        endfunction

        function int unsigned divisor();
            if (entries == '0) begin
                return 1;
            end
            if (int'(entries) > hbmt_pkg::TABLE_DEPTH) begin
                return hbmt_pkg::TABLE_DEPTH;
            end
            return 32'(entries);
        endfunction

        function void set_entries(input logic [hbmt_pkg::CFG_BITS-1:0] value);
            entries = value;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        function void note_request(input logic [1:0] mode,
                                   input logic [hbmt_pkg::KEY_BITS-1:0] key,
                                   input logic [hbmt_pkg::MOVE_BITS-1:0] move);
            int unsigned    slot;
            t_lookup_result res;
            slot = int'(key % 64'(divisor()));
            res  = '0;
            case (mode)
                hbmt_pkg::MODE_CLEAR: begin
                    wipe_table();
                    clears++;
                end
                hbmt_pkg::MODE_STORE: begin
                    slot_key[slot]  = key;
                    slot_move[slot] = move;
                    stores++;
                end
                hbmt_pkg::MODE_PROBE: begin
                    probes++;
                    if (slot_key[slot] == key) begin
                        res.hit        = 1'b1;
                        res.found_move = slot_move[slot];
                        hits++;
                    end
                end
                default: begin
                    unused++;
                end
            endcase
            expected_lookups.push_back(res);
        endfunction

        function void check_result(input logic hit,
                                   input logic [hbmt_pkg::MOVE_BITS-1:0] move);
            t_lookup_result exp_res;
            checked++;
            if (expected_lookups.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result: hit=%0b found_move=0x%07h", hit, move);
                end
                return;
            end
            exp_res = expected_lookups.pop_front();
            if (hit !== exp_res.hit || move !== exp_res.found_move) begin
                errors++;
                if (errors <= 10) begin
                    $display("Result %0d: expected hit=%0b move=0x%07h, got hit=%0b move=0x%07h",
                             checked, exp_res.hit, exp_res.found_move, hit, move);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_enable;
    int   cycle_count;
    int   settings_used;

    logic [hbmt_pkg::KEY_BITS-1:0] key_pool[$];
    t_best_move_scoreboard         sb;

    hbmt_in_if  in_ch ();
    hbmt_out_if out_ch ();
    hbmt_cfg_if cfg_ch ();

    hashed_best_move_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.hit, out_ch.found_move);
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_request(in_ch.mode, in_ch.hash_key, in_ch.move_code);
        end
    end

    always begin
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        out_ch.ready <= 1'b1;
    end

    task automatic send_request(input logic [1:0] mode,
                                input logic [hbmt_pkg::KEY_BITS-1:0] key,
                                input logic [hbmt_pkg::MOVE_BITS-1:0] move);
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.hash_key  <= key;
        in_ch.move_code <= move;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic write_entries(input logic [hbmt_pkg::CFG_BITS-1:0] value);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.entries_in_use <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_entries(value);
        settings_used++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [hbmt_pkg::KEY_BITS-1:0] pick_key();
        int unsigned                   sel;
        logic [hbmt_pkg::KEY_BITS-1:0] base;
        sel = $urandom_range(0, 9);
        if (sel == 6) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return 64'($urandom_range(0, 4200));
            endcase
        end
        if (key_pool.size() == 0 || sel >= 7) begin
            return {$urandom, $urandom};
        end
        base = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (sel <= 3) begin
            return base;
        end
        return base + 64'(sb.divisor()) * 64'($urandom_range(1, 50));
    endfunction

    task automatic run_random_phase(input int count);
        int unsigned                   pick;
        logic [1:0]                    mode;
        logic [hbmt_pkg::KEY_BITS-1:0] key;
        repeat (count) begin
            pick = $urandom_range(0, 127);
            if (pick < 2) begin
                mode = hbmt_pkg::MODE_CLEAR;
            end else if (pick < 5) begin
                mode = MODE_UNUSED;
            end else if (pick < 64) begin
                mode = hbmt_pkg::MODE_STORE;
            end else begin
                mode = hbmt_pkg::MODE_PROBE;
            end
            key = pick_key();
            if (mode == hbmt_pkg::MODE_STORE) begin
                key_pool.push_back(key);
                if (key_pool.size() > POOL_LIMIT) begin
                    void'(key_pool.pop_front());
                end
            end
            send_request(mode, key, hbmt_pkg::MOVE_BITS'($urandom));
        end
    endtask

    initial begin
        logic [hbmt_pkg::CFG_BITS-1:0] settings[$];
        sb                    = new();
        idle_enable           = 1'b1;
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.mode            = hbmt_pkg::MODE_CLEAR;
        in_ch.hash_key        = '0;
        in_ch.move_code       = '0;
        out_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.entries_in_use = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(hbmt_pkg::MODE_PROBE, 64'h0, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, '1, 25'h0);
        send_request(hbmt_pkg::MODE_STORE, '1, '1);
        send_request(hbmt_pkg::MODE_PROBE, '1, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'h0000_0000_0000_0FFF, '1);
        send_request(hbmt_pkg::MODE_STORE, 64'h8000_0000_0000_0000, 25'h155_5555);
        send_request(hbmt_pkg::MODE_PROBE, 64'h0, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'h8000_0000_0000_0000, 25'h0);
        send_request(hbmt_pkg::MODE_STORE, 64'h5555_5555_AAAA_AAAA, 25'h0AA_AAAA);
        send_request(hbmt_pkg::MODE_PROBE, 64'h5555_5555_AAAA_AAAA, 25'h0);
        send_request(MODE_UNUSED, '1, '1);
        send_request(hbmt_pkg::MODE_PROBE, '1, 25'h0);
        send_request(hbmt_pkg::MODE_STORE, 64'h0, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'h0, 25'h0);
        send_request(hbmt_pkg::MODE_CLEAR, '1, '1);
        send_request(hbmt_pkg::MODE_PROBE, '1, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'h8000_0000_0000_0000, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'h0, 25'h0);
        send_request(hbmt_pkg::MODE_STORE, 64'd5, 25'h1);
        send_request(hbmt_pkg::MODE_PROBE, 64'd5, 25'h0);
        send_request(hbmt_pkg::MODE_STORE, 64'd4101, 25'h2);
        send_request(hbmt_pkg::MODE_PROBE, 64'd5, 25'h0);
        send_request(hbmt_pkg::MODE_PROBE, 64'd4101, 25'h0);

        settings = '{13'd0, 13'd1, 13'h1FFF, 13'd4097, 13'd3, 13'd100, 13'd4095,
                     hbmt_pkg::CFG_BITS'($urandom_range(2, 4094)), 13'd4096};
        foreach (settings[i]) begin
            write_entries(settings[i]);
            if (i == settings.size() - 1) begin
                idle_enable = 1'b0;
            end
            run_random_phase(80);
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Checked %0d results: %0d stores, %0d probes (%0d hits), %0d clears, %0d unused",
                 sb.checked, sb.stores, sb.probes, sb.hits, sb.clears, sb.unused);
        $display("Table size was rewritten %0d times, including zero and out-of-range values",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
